// ===== sv/hpsle_pkg.sv =====
// Package for the HPACK status / content-length header encoder.
// Holds field widths, HPACK byte constants and the job record passed from
// front to back. No dependencies.
package hpsle_pkg;

    // Input and output field widths
    localparam int STATUS_W    = 10;
    localparam int LENGTH_W    = 64;
    localparam int IN_DATA_W   = 80;   // 10 + 64 bits, padded to whole bytes
    localparam int OUT_DATA_W  = 8;

    // Decimal conversion: 20 BCD digits cover any 64-bit value
    localparam int BCD_DIGITS  = 20;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int DIG_IDX_W   = 5;
    localparam int STEP_W      = 6;
    localparam int STATUS_DIGITS = 3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // HPACK bytes
    localparam logic [7:0] HP_INDEXED_BIT = 8'h80;
    localparam logic [7:0] HP_LIT_NAME    = 8'h08;  // literal, name index 8 (:status)
    localparam logic [7:0] HP_LIT_LEN     = 8'h03;  // three status digits
    localparam logic [7:0] HP_CL_NAME     = 8'h0F;  // literal, name index 28 ...
    localparam logic [7:0] HP_CL_NAME_EXT = 8'h0D;  // ... continuation byte
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // What kind of run a job becomes
    typedef enum logic [1:0] {
        K_INDEXED = 2'd0,
        K_LITERAL = 2'd1,
        K_LENGTH  = 2'd2
    } t_kind;

    // One classified request
    typedef struct packed {
        t_kind                kind;
        logic [7:0]           idx_byte;   // indexed byte for common status codes
        logic [LENGTH_W-1:0]  value;      // number to print in decimal
    } t_job;

endpackage

// ===== sv/hpack_status_length_encoder_top.sv =====
// Channel | Dir | Payload                                  | Per request
// s       | in  | tdata: status_code, content_length; tuser: req_type | one
// m       | out | tdata: out_byte; tlast: last              | 1 to 23 bytes
//
// Top level of the HPACK status / content-length encoder. Depends on hpsle_pkg,
// hpsle_front, hpsle_queue and hpsle_back.
// A content-length request takes 64 conversion steps in the shift-and-adjust
// unit, then a digit count, then emits one output byte at a time.
// A literal status takes 10 conversion steps; an indexed status skips conversion.
// Requests queue up to QUEUE_DEPTH deep while the back part works.
// Reset is synchronous, active low, and empties queue and output register.
// Output stalls hold the current byte and stop byte emission (not conversion);
// the input side keeps accepting until the queue is full.
module hpack_status_length_encoder_top
    import hpsle_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [9:0] status_code, [73:10] content_length
    input  logic                  i_s_tuser,   // [0] req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [7:0] out_byte
    output logic                  o_m_tlast
);

    t_job front_job;
    t_job head_job;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_s_tready = !q_full;

    // Classify the request
    hpsle_front u_front (
        .i_req_type       (i_s_tuser),
        .i_status_code    (i_s_tdata[STATUS_W-1:0]),
        .i_content_length (i_s_tdata[STATUS_W +: LENGTH_W]),
        .o_job            (front_job)
    );

    // Hold jobs between front and back
    hpsle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // Convert and emit bytes
    hpsle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== sv/hpsle_front.sv =====
// Front part of the HPACK header encoder: decodes one request and classifies
// it into a job record for the queue. Depends on hpsle_pkg.
module hpsle_front
    import hpsle_pkg::*;
(
    input  logic                 i_req_type,
    input  logic [STATUS_W-1:0]  i_status_code,
    input  logic [LENGTH_W-1:0]  i_content_length,
    output t_job                 o_job
);

    logic [STATUS_W-1:0] status_mod;
    logic [7:0]          idx_byte;
    logic                hit;

    // Map the common status codes onto static table entries 8..14
    always_comb begin
        hit      = 1'b1;
        idx_byte = HP_INDEXED_BIT;
        case (i_status_code)
            10'd200: idx_byte = HP_INDEXED_BIT | 8'd8;
            10'd204: idx_byte = HP_INDEXED_BIT | 8'd9;
            10'd206: idx_byte = HP_INDEXED_BIT | 8'd10;
            10'd304: idx_byte = HP_INDEXED_BIT | 8'd11;
            10'd400: idx_byte = HP_INDEXED_BIT | 8'd12;
            10'd404: idx_byte = HP_INDEXED_BIT | 8'd13;
            10'd500: idx_byte = HP_INDEXED_BIT | 8'd14;
            default: hit = 1'b0;
        endcase
    end

    // Keep three digits: codes of 1000 and above wrap once
    assign status_mod = (i_status_code >= 10'd1000) ? (i_status_code - 10'd1000)
                                                    : i_status_code;

    // Build the job record
    always_comb begin
        o_job.idx_byte = idx_byte;
        if (i_req_type) begin
            o_job.kind  = K_LENGTH;
            o_job.value = i_content_length;
        end else begin
            o_job.kind  = hit ? K_INDEXED : K_LITERAL;
            o_job.value = {{(LENGTH_W-STATUS_W){1'b0}}, status_mod};
        end
    end

endmodule

// ===== sv/hpsle_queue.sv =====
// Short job queue between the front and back parts of the HPACK encoder.
// Register-based circular buffer. Depends on hpsle_pkg.
module hpsle_queue
    import hpsle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/hpsle_back.sv =====
// Back part of the HPACK encoder: double-dabble conversion to decimal, one
// shift step a cycle, then byte-by-byte emission through an output register.
// Depends on hpsle_pkg.
module hpsle_back
    import hpsle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_HDR,
        ST_DIG
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    logic [7:0]            r_idx;
    logic [LENGTH_W-1:0]   r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [STEP_W-1:0]     r_step;
    logic [DIG_IDX_W-1:0]  r_nd;
    logic [1:0]            r_pos;
    logic [DIG_IDX_W-1:0]  r_dig;
    logic                  r_valid;
    logic [7:0]            r_byte;
    logic                  r_last;

    logic [BCD_W-1:0]      bcd_adj;
    logic [DIG_IDX_W-1:0]  dig_count;
    logic [3:0]            dig_sel;
    logic [1:0]            hdr_last_pos;
    logic [7:0]            hdr_byte;
    logic                  out_free;
    logic                  byte_emit;

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign out_free   = !r_valid || i_m_tready;
    assign byte_emit  = out_free && ((r_state == ST_HDR) || (r_state == ST_DIG));
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tlast  = r_last;

    // Add three to every BCD digit of five or more
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                           : r_bcd[4*i +: 4];
        end
    end

    // Count significant digits, at least one
    always_comb begin
        dig_count = DIG_IDX_W'(1);
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                dig_count = DIG_IDX_W'(i + 1);
            end
        end
    end

    assign dig_sel = r_bcd[{r_dig, 2'b00} +: 4];

    // Header bytes of the run
    always_comb begin
        case (r_kind)
            K_INDEXED: hdr_last_pos = 2'd0;
            K_LITERAL: hdr_last_pos = 2'd1;
            default:   hdr_last_pos = 2'd2;
        endcase
        case (r_pos)
            2'd0: begin
                case (r_kind)
                    K_INDEXED: hdr_byte = r_idx;
                    K_LITERAL: hdr_byte = HP_LIT_NAME;
                    default:   hdr_byte = HP_CL_NAME;
                endcase
            end
            2'd1:    hdr_byte = (r_kind == K_LITERAL) ? HP_LIT_LEN : HP_CL_NAME_EXT;
            default: hdr_byte = {{(8-DIG_IDX_W){1'b0}}, r_nd};
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (i_m_tready && !byte_emit) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_kind <= i_job.kind;
                        r_idx  <= i_job.idx_byte;
                        r_bcd  <= '0;
                        r_pos  <= 2'd0;
                        case (i_job.kind)
                            K_INDEXED: begin
                                r_nd    <= '0;
                                r_state <= ST_HDR;
                            end
                            K_LITERAL: begin
                                r_bin   <= {i_job.value[STATUS_W-1:0],
                                            {(LENGTH_W-STATUS_W){1'b0}}};
                                r_step  <= STEP_W'(STATUS_W - 1);
                                r_state <= ST_CONV;
                            end
                            default: begin
                                r_bin   <= i_job.value;
                                r_step  <= STEP_W'(LENGTH_W - 1);
                                r_state <= ST_CONV;
                            end
                        endcase
                    end
                end
                ST_CONV: begin
                    r_bcd  <= {bcd_adj[BCD_W-2:0], r_bin[LENGTH_W-1]};
                    r_bin  <= {r_bin[LENGTH_W-2:0], 1'b0};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    r_nd    <= (r_kind == K_LENGTH) ? dig_count
                                                    : DIG_IDX_W'(STATUS_DIGITS);
                    r_state <= ST_HDR;
                end
                ST_HDR: begin
                    if (out_free) begin
                        r_valid <= 1'b1;
                        r_byte  <= hdr_byte;
                        r_last  <= (r_pos == hdr_last_pos) && (r_nd == '0);
                        if (r_pos == hdr_last_pos) begin
                            r_dig   <= r_nd - 1'b1;
                            r_state <= (r_nd == '0) ? ST_IDLE : ST_DIG;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                ST_DIG: begin
                    if (out_free) begin
                        r_valid <= 1'b1;
                        r_byte  <= ASCII_ZERO | {4'd0, dig_sel};
                        r_last  <= (r_dig == '0);
                        r_dig   <= r_dig - 1'b1;
                        if (r_dig == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/hpsle_checker.sv =====
// Port-level checker for the HPACK encoder output stream, with its bind to the
// top level. Depends on hpsle_pkg.
module hpsle_checker
    import hpsle_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    logic r_first;
    logic first_ok;

    // Track whether the next byte opens a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            r_first <= o_m_tlast;
        end
    end

    assign first_ok = (o_m_tdata == HP_LIT_NAME) || (o_m_tdata == HP_CL_NAME) ||
                      ((o_m_tdata[7:4] == 4'h8) && (o_m_tdata[3] == 1'b1) &&
                       (o_m_tdata[3:0] != 4'hF));

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    a_run_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_first |-> first_ok)
        else $error("run opens with an unexpected byte");

    a_indexed_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_first && o_m_tdata[7] |-> o_m_tlast)
        else $error("indexed status byte not alone in its run");

endmodule

bind hpack_status_length_encoder_top hpsle_checker u_checker (.*);
